@@ rtl/circular_deque_unit_defines.svh @@
// Assertion macros used by the circular deque core.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cdq_pkg.sv @@
// Package: action codes, defaults and shared types of the circular deque.
`timescale 1ns / 1ps
package cdq_pkg;

	localparam int DEPTH_DEF      = 128;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [2:0] ACT_POP_BACK   = 3'd4;
	localparam logic [2:0] ACT_CLEAR      = 3'd5;

	typedef struct packed {
		logic popped_valid;
		logic push_rejected;
	} res_flags_t;

endpackage

@@ rtl/cdq_store.sv @@
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cdq_store #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cdq_core.sv @@
// Deque control: pointers, occupancy, end-word cache and slot memory writes and reads.
`timescale 1ns / 1ps
`include "circular_deque_unit_defines.svh"
module cdq_core #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] value_in,
	output logic                         busy,
	output logic                         res_valid,
	output cdq_pkg::res_flags_t          res_flags,
	output logic [DATA_WIDTH-1:0]        res_popped,
	output logic [CW-1:0]                res_count,
	output logic [DATA_WIDTH-1:0]        res_front,
	output logic [DATA_WIDTH-1:0]        res_back
);

	typedef enum logic {S_IDLE, S_RESP} state_t;
	typedef enum logic [1:0] {LD_NONE, LD_FRONT, LD_BACK} ld_t;

	state_t              state_q;
	ld_t                 ld_q, ld_d;
	logic [AW-1:0]       head_q, head_d, tail_q, tail_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	cdq_pkg::res_flags_t flags_q, flags_d;
	logic [DATA_WIDTH-1:0] front_q, front_d, back_q, back_d, popped_q, popped_d;
	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  accept, full;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign busy   = (state_q == S_RESP);
	assign accept = start && !busy;
	assign full   = (cnt_q == CW'(DEPTH));

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		front_d  = front_q;
		back_d   = back_q;
		popped_d = '0;
		flags_d  = '0;
		ld_d     = LD_NONE;
		we       = 1'b0;
		waddr    = tail_q;
		raddr    = head_q;
		case (action)
			cdq_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					flags_d.push_rejected = 1'b1;
				end else begin
					head_d  = prev_idx(head_q);
					waddr   = head_d;
					we      = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					front_d = value_in;
					if (cnt_q == '0) begin
						back_d = value_in;
					end
				end
			end
			cdq_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					flags_d.push_rejected = 1'b1;
				end else begin
					waddr  = tail_q;
					we     = 1'b1;
					tail_d = next_idx(tail_q);
					cnt_d  = cnt_q + 1'b1;
					back_d = value_in;
					if (cnt_q == '0) begin
						front_d = value_in;
					end
				end
			end
			cdq_pkg::ACT_POP_FRONT: begin
				if (cnt_q != '0) begin
					popped_d             = front_q;
					flags_d.popped_valid = 1'b1;
					head_d               = next_idx(head_q);
					cnt_d                = cnt_q - 1'b1;
					if (cnt_q == CW'(2)) begin
						front_d = back_q;
					end else if (cnt_q > CW'(2)) begin
						raddr = head_d;
						ld_d  = LD_FRONT;
					end
				end
			end
			cdq_pkg::ACT_POP_BACK: begin
				if (cnt_q != '0) begin
					popped_d             = back_q;
					flags_d.popped_valid = 1'b1;
					tail_d               = prev_idx(tail_q);
					cnt_d                = cnt_q - 1'b1;
					if (cnt_q == CW'(2)) begin
						back_d = front_q;
					end else if (cnt_q > CW'(2)) begin
						raddr = prev_idx(tail_d);
						ld_d  = LD_BACK;
					end
				end
			end
			cdq_pkg::ACT_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				cnt_d  = '0;
			end
			default: begin
			end
		endcase
	end

	cdq_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (accept && we),
		.waddr (waddr),
		.wdata (value_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			flags_q <= '0;
			ld_q    <= LD_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						cnt_q   <= cnt_d;
						flags_q <= flags_d;
						ld_q    <= ld_d;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = (state_q == S_RESP);
	assign res_flags  = flags_q;
	assign res_popped = popped_q;
	assign res_count  = cnt_q;
	assign res_front  = (ld_q == LD_FRONT) ? rdata : front_q;
	assign res_back   = (ld_q == LD_BACK) ? rdata : back_q;

	// load the end-word cache on accept; fold the fetched end word back in on response
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q  <= front_d;
			back_q   <= back_d;
			popped_q <= popped_d;
		end else if (state_q == S_RESP) begin
			front_q <= res_front;
			back_q  <= res_back;
		end
	end

	`CDQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "occupancy beyond depth")
	`CDQ_ASSERT_NOW(a_empty_ptrs, cnt_q == '0, head_q == tail_q, "empty deque with split pointers")
	`CDQ_ASSERT_NEXT(a_reject_hold, accept && flags_d.push_rejected, $stable(cnt_q), "rejected push changed occupancy")
	`CDQ_ASSERT_NOW(a_flags_excl, res_valid, !(flags_q.popped_valid && flags_q.push_rejected), "pop and reject flagged together")

endmodule

@@ rtl/circular_deque_unit.sv @@
// Top level of the circular deque: command port, core and result register.
// Use: drive action and value_in with start high while busy is low; the word
// is taken at that clock edge. Actions are none, push front, push back,
// pop front, pop back and clear; codes 6 and 7 do nothing.
// Each accepted word yields one result: done is registered from the core's
// response state and stays high for exactly one cycle, with
// popped_value/popped_valid, push_rejected, entry_count, is_empty, head_value
// and tail_value showing the deque after the action. The result registers
// load at the same edge that raises done. head_value and tail_value read zero
// when empty.
// No new word is taken while busy is high. busy is high for the single cycle
// in which the slot memory read (one port, registered output) completes; the
// next word may be taken in the same cycle that the previous result is shown.
// The receiver cannot stall: a result not taken while done is high is lost.
// Reset (arst_n low) empties the deque and returns both ends to slot 0; slot
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module circular_deque_unit #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] value_in,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] popped_value,
	output logic                         popped_valid,
	output logic                         push_rejected,
	output logic [CW-1:0]                entry_count,
	output logic                         is_empty,
	output logic signed [DATA_WIDTH-1:0] head_value,
	output logic signed [DATA_WIDTH-1:0] tail_value
);

	logic                  res_valid;
	cdq_pkg::res_flags_t   res_flags;
	logic [DATA_WIDTH-1:0] res_popped, res_front, res_back;
	logic [CW-1:0]         res_count;
	logic                  done_q;

	cdq_core #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.value_in   (value_in),
		.busy       (busy),
		.res_valid  (res_valid),
		.res_flags  (res_flags),
		.res_popped (res_popped),
		.res_count  (res_count),
		.res_front  (res_front),
		.res_back   (res_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	// register the result word; mask end words when empty
	always_ff @(posedge clk) begin
		if (res_valid) begin
			popped_value  <= res_popped;
			popped_valid  <= res_flags.popped_valid;
			push_rejected <= res_flags.push_rejected;
			entry_count   <= res_count;
			is_empty      <= (res_count == '0);
			head_value    <= (res_count == '0) ? '0 : res_front;
			tail_value    <= (res_count == '0) ? '0 : res_back;
		end
	end

	assign done = done_q;

endmodule
